FILE: hw/rtl/rmsd_pkg.sv
// Types, register codes and the decay table for the match score block.
`default_nettype none
package rmsd_pkg;

	typedef struct packed {
		logic        restart;
		logic [31:0] squared_dist;
	} rmsd_in_t;

	typedef struct packed {
		logic [31:0] score;
		logic [15:0] match_count;
	} rmsd_out_t;

	localparam logic [1:0] CFG_NORM_MODE    = 2'd0;
	localparam logic [1:0] CFG_COUNT_FIRST  = 2'd1;
	localparam logic [1:0] CFG_COUNT_SECOND = 2'd2;
	localparam logic [1:0] CFG_RMS_GAIN     = 2'd3;

	localparam logic [1:0] MODE_MIN    = 2'd0;
	localparam logic [1:0] MODE_AVG    = 2'd1;
	localparam logic [1:0] MODE_ONE    = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int EXP_BITS = 29;

	// exp(-2^(b-24)) scaled by 2^32, rounded
	localparam logic [31:0] DECAY_TABLE [0:EXP_BITS-1] = '{
		32'd4294967040, 32'd4294966784, 32'd4294966272, 32'd4294965248,
		32'd4294963200, 32'd4294959104, 32'd4294950912, 32'd4294934528,
		32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
		32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
		32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
		32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
		32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
		32'd483
	};

endpackage
`default_nettype wire

FILE: hw/rtl/rmsd_match_score_top.sv
// Running point-matching score: accumulator, sequencer and shared arithmetic.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid / in_stall   | in_data  (restart, squared_dist)
//  out     | source    | out_valid / out_stall | out_data (score, match_count)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each transaction steps from acceptance through the mean division, the square
// root, the gain product, the exponential, the count product, the normalizing
// division and the hand-over of the result; the exponential is skipped when the
// exponent is so large that the decay underflows to zero. One shared subtractor
// and one shared multiplier serve these steps in turn; in_stall stays high for
// the whole time, and longer while a full output register holds the finished
// result back.
// The finished result sits in an output register, so the next transaction is
// taken while it still waits on out_stall. Reset clears sum, count, control and
// restores the register defaults. cfg_ready is always high.
`default_nettype none
module rmsd_match_score_top
	import rmsd_pkg::*;
#(
	parameter int unsigned MAX_MATCHES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire rmsd_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output rmsd_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int unsigned CAP_I = (MAX_MATCHES < 65535) ? MAX_MATCHES : 65535;
	localparam logic [15:0] CAP   = CAP_I[15:0];
	localparam logic [48:0] SUM_LIMIT = {1'b0, {48{1'b1}}};

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV1 = 8'b0000_0010,
		S_SQRT = 8'b0000_0100,
		S_MULX = 8'b0000_1000,
		S_EXP  = 8'b0001_0000,
		S_MUL2 = 8'b0010_0000,
		S_DIV2 = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [1:0]  norm_mode_q;
	logic [15:0] count_first_q;
	logic [15:0] count_second_q;
	logic [23:0] rms_gain_q;
	logic [47:0] dist_sum_q;
	logic [15:0] pair_count_q;
	logic [63:0] rad_q;    // dividend / quotient, or radicand
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [24:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [28:0] x_q;
	logic [32:0] e_q;
	logic [31:0] score_q;
	rmsd_out_t   out_q;
	logic        out_valid_q;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q    <= MODE_MIN;
			count_first_q  <= 16'd1;
			count_second_q <= 16'd1;
			rms_gain_q     <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NORM_MODE:    norm_mode_q    <= cfg_data[1:0];
				CFG_COUNT_FIRST:  count_first_q  <= cfg_data[15:0];
				CFG_COUNT_SECOND: count_second_q <= cfg_data[15:0];
				CFG_RMS_GAIN:     rms_gain_q     <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Accumulate on acceptance
	logic        in_acc;
	logic [47:0] sum_base;
	logic [48:0] sum_add;
	logic [47:0] sum_next;
	logic [15:0] cnt_base;
	logic [15:0] cnt_next;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		sum_base = in_data.restart ? 48'd0 : dist_sum_q;
		cnt_base = in_data.restart ? 16'd0 : pair_count_q;
		sum_add  = {1'b0, sum_base} + {17'd0, in_data.squared_dist};
		sum_next = (sum_add > SUM_LIMIT) ? SUM_LIMIT[47:0] : sum_add[47:0];
		cnt_next = (cnt_base < CAP) ? cnt_base + 16'd1 : cnt_base;
	end

	// Divisor in half units, shifted into Q.8
	logic [16:0] d2;
	always_comb begin
		case (norm_mode_q)
			MODE_MIN: d2 = (count_first_q < count_second_q) ?
				{count_first_q, 1'b0} : {count_second_q, 1'b0};
			MODE_AVG: d2 = {1'b0, count_first_q} + {1'b0, count_second_q};
			default:  d2 = 17'd2;
		endcase
		if (d2 == 17'd0) begin
			d2 = 17'd2;
		end
	end

	// Shared subtractor: restoring division step or square-root digit step
	logic [34:0] sub_a;
	logic [34:0] sub_b;
	logic [35:0] sub_d;
	logic        sub_ge;

	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {rem_q[32:0], rad_q[63:62]};
			sub_b = {1'b0, root_q, 2'b01};
		end else begin
			sub_a = {9'd0, rem_q[24:0], rad_q[49]};
			sub_b = {10'd0, dvs_q};
		end
		sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_d[35];
	end

	// Shared multiplier
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] mul_p;

	always_comb begin
		case (state_q)
			S_MULX:  begin
				mul_a = {1'b0, root_q};
				mul_b = {8'd0, rms_gain_q};
			end
			S_EXP:   begin
				mul_a = e_q;
				mul_b = DECAY_TABLE[cnt_q[4:0]];
			end
			default: begin
				mul_a = e_q;
				mul_b = {16'd0, pair_count_q};
			end
		endcase
		mul_p = {32'd0, mul_a} * {33'd0, mul_b};
	end

	logic [49:0] quo_next;
	logic [64:0] e_round;
	assign quo_next = {rad_q[48:0], sub_ge};
	assign e_round  = mul_p + 65'h0_8000_0000;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			dist_sum_q   <= '0;
			pair_count_q <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						dist_sum_q   <= sum_next;
						pair_count_q <= cnt_next;
						cnt_q        <= 6'd49;
						state_q      <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (cnt_q == 6'd0) begin
						cnt_q   <= 6'd31;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_MULX;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_MULX: begin
					cnt_q   <= 6'd0;
					// skip the exponential when the decay underflows to zero
					state_q <= (|mul_p[55:37]) ? S_MUL2 : S_EXP;
				end
				S_EXP: begin
					if (cnt_q == 6'(EXP_BITS - 1)) begin
						state_q <= S_MUL2;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_MUL2: begin
					cnt_q   <= 6'd49;
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rad_q <= {16'd0, sum_next};
				rem_q <= '0;
				dvs_q <= {9'd0, cnt_next};
			end
			S_DIV1: begin
				if (cnt_q == 6'd0) begin
					// quotient is the mean; scale it up for the root
					rad_q  <= {quo_next[47:0], 16'd0};
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= sub_ge ? sub_d[34:0] : sub_a;
					rad_q <= {14'd0, quo_next};
				end
			end
			S_SQRT: begin
				rem_q  <= sub_ge ? sub_d[34:0] : sub_a;
				rad_q  <= {rad_q[61:0], 2'b00};
				root_q <= {root_q[30:0], sub_ge};
			end
			S_MULX: begin
				x_q <= mul_p[36:8];
				e_q <= (|mul_p[55:37]) ? 33'd0 : {1'b1, 32'd0};
			end
			S_EXP: begin
				if (x_q[cnt_q[4:0]]) begin
					e_q <= e_round[64:32];
				end
			end
			S_MUL2: begin
				rad_q <= {14'd0, mul_p[48:0], 1'b0};
				rem_q <= '0;
				dvs_q <= {d2, 8'd0};
			end
			S_DIV2: begin
				rem_q <= sub_ge ? sub_d[34:0] : sub_a;
				rad_q <= {14'd0, quo_next};
				if (cnt_q == 6'd0) begin
					score_q <= (|quo_next[49:32]) ? 32'hFFFF_FFFF : quo_next[31:0];
				end
			end
			default: ;
		endcase
	end

	// Output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_q.score       <= score_q;
			out_q.match_count <= pair_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_DIV1)
		else $error("accepted transaction did not start the division");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.match_count != 16'd0)
		else $error("result carries a zero match count");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> rem_q[34:33] == 2'b00)
		else $error("square root remainder overflow");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || !out_stall)) |=>
		(out_valid_q && state_q == S_IDLE))
		else $error("finished result not loaded");

endmodule
`default_nettype wire
